### hw/rtl/ffha_pkg.sv
// Package: item types, table entry type, status codes and controller states.
package ffha_pkg;

  localparam int unsigned SizeW = 23;
  localparam int unsigned AddrW = 32;
  localparam int unsigned StsW  = 3;
  localparam int unsigned CntOW = 9;

  localparam logic [StsW-1:0] STS_OK    = 3'd0;
  localparam logic [StsW-1:0] STS_NULL  = 3'd1;
  localparam logic [StsW-1:0] STS_OOM   = 3'd2;
  localparam logic [StsW-1:0] STS_DBL   = 3'd3;
  localparam logic [StsW-1:0] STS_UNK   = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic             func;
    logic [SizeW-1:0] req_size;
    logic [AddrW-1:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [StsW-1:0]  status;
    logic [AddrW-1:0] alloc_addr;
    logic [SizeW-1:0] used_bytes;
    logic [SizeW-1:0] free_bytes;
    logic [SizeW-1:0] largest_free;
    logic [CntOW-1:0] block_count;
  } out_item_t;

  // One block of the table: header offset from the base, payload size, free mark.
  typedef struct packed {
    logic             is_free;
    logic [SizeW-1:0] offset;
    logic [SizeW-1:0] size;
  } ent_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_SHR_RD,
    S_SHR_WR,
    S_SPLIT_WR,
    S_ALC_WR,
    S_NXT_RD,
    S_NXT_CHK,
    S_MERGE,
    S_SHL_RD,
    S_SHL_WR,
    S_STAT_RD,
    S_STAT_ACC,
    S_DONE
  } state_e;

endpackage

### hw/rtl/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator with coalescing over a block table RAM.
//
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_item_i): one allocate or free request.
//   out channel (out_valid_o/out_ready_i/out_item_o): one result item per request
//   with status, payload address and heap statistics.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): heap_base, always ready;
//   write it only while the block is idle. The table is kept, addresses move.
// Walks: the table sits in a RAM with one registered read port, and every
//   walk step is a read state followed by a check or write state.
//   An item walks the search, any shift of entries and then the whole table
//   for the statistics.
//   One item is in flight at a time; in_ready_o is high while idle.
// Reset: one cycle after reset releases, entry 0 is written as a single free
//   block covering the heap; in_ready_o stays low during that cycle.
// Stall: the finished result sits in an output register; a new item can be
//   taken while it waits, but the next result waits until it is taken.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES      = 4194304,
  parameter int unsigned HEADER_BYTES    = 16,
  parameter int unsigned MIN_SPLIT_BYTES = 8,
  parameter int unsigned MAX_BLOCKS      = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffha_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ffha_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);
  import ffha_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW    = CNT_W + 1;
  localparam int unsigned NeedW = SizeW + 1;
  localparam int unsigned SplitGap = HEADER_BYTES + MIN_SPLIT_BYTES;
  localparam logic [SizeW-1:0] HDR = SizeW'(HEADER_BYTES);

  state_e state_q, state_d;

  logic             func_q, func_d;
  logic [NeedW-1:0] need_q, need_d;
  logic [AddrW-1:0] faddr_q, faddr_d;
  logic [AddrW-1:0] base_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;   // scan index, then position of the hit
  logic [CNT_W-1:0] k_q, k_d;       // shift / statistics pointer
  logic [1:0]       dist_q, dist_d; // entries removed by a merge
  logic             split_q, split_d;
  logic             nm_q, nm_d;     // next neighbor merged
  ent_t             cur_q, cur_d;
  ent_t             prev_q, prev_d;
  logic [StsW-1:0]  sts_q, sts_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [SizeW-1:0] used_q, used_d, fsum_q, fsum_d, big_q, big_d;
  out_item_t        out_q;
  logic             out_valid_q;

  // RAM port
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  ent_t             wdata, rdata;

  ffha_ram #(.DEPTH(MAX_BLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic             in_acc, zero_req, out_free;
  logic [AddrW-1:0] paddr;
  logic             hit, last_ent, can_split, shr_more, pm, mrg_more, shl_more;
  logic [EW-1:0]    dst;
  logic [1:0]       mdist;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign zero_req    = (in_item_i.func == FUNC_ALLOC) ? (in_item_i.req_size == '0)
                                                      : (in_item_i.free_addr == '0);

  assign paddr     = base_q + AddrW'(rdata.offset) + AddrW'(HEADER_BYTES);
  assign hit       = (func_q == FUNC_ALLOC)
                   ? (rdata.is_free && ({1'b0, rdata.size} >= need_q))
                   : (paddr == faddr_q);
  assign last_ent  = (EW'(idx_q) + EW'(1)) >= EW'(cnt_q);
  assign can_split = ({2'b0, rdata.size} >= ({1'b0, need_q} + (NeedW + 1)'(SplitGap)))
                   && (EW'(cnt_q) < EW'(MAX_BLOCKS));
  assign shr_more  = (EW'(k_q) - EW'(1)) > (EW'(idx_q) + EW'(1));
  assign pm        = (idx_q != '0) && prev_q.is_free;
  assign mdist     = {1'b0, nm_q} + {1'b0, pm};
  assign dst       = pm ? EW'(idx_q) : EW'(idx_q) + EW'(1);
  assign mrg_more  = (dst + EW'(mdist)) < EW'(cnt_q);
  assign shl_more  = (EW'(k_q) + EW'(1) + EW'(dist_q)) < EW'(cnt_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:    state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) state_d = zero_req ? S_STAT_RD : S_FIND_RD;
      end
      S_FIND_RD: state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        if (hit) begin
          if (func_q == FUNC_ALLOC) begin
            if (!can_split) state_d = S_ALC_WR;
            else if (EW'(cnt_q) > EW'(idx_q) + EW'(1)) state_d = S_SHR_RD;
            else state_d = S_SPLIT_WR;
          end else if (rdata.is_free) begin
            state_d = S_STAT_RD;
          end else begin
            state_d = last_ent ? S_MERGE : S_NXT_RD;
          end
        end else begin
          state_d = last_ent ? S_STAT_RD : S_FIND_RD;
        end
      end
      S_SHR_RD:   state_d = S_SHR_WR;
      S_SHR_WR:   state_d = shr_more ? S_SHR_RD : S_SPLIT_WR;
      S_SPLIT_WR: state_d = S_ALC_WR;
      S_ALC_WR:   state_d = S_STAT_RD;
      S_NXT_RD:   state_d = S_NXT_CHK;
      S_NXT_CHK:  state_d = S_MERGE;
      S_MERGE:    state_d = (mdist != 2'd0 && mrg_more) ? S_SHL_RD : S_STAT_RD;
      S_SHL_RD:   state_d = S_SHL_WR;
      S_SHL_WR:   state_d = shl_more ? S_SHL_RD : S_STAT_RD;
      S_STAT_RD:  state_d = S_STAT_ACC;
      S_STAT_ACC: begin
        state_d = ((EW'(k_q) + EW'(1)) >= EW'(cnt_q)) ? S_DONE : S_STAT_RD;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default:    state_d = S_INIT;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    func_d  = func_q;
    need_d  = need_q;
    faddr_d = faddr_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    k_d     = k_q;
    dist_d  = dist_q;
    split_d = split_q;
    nm_d    = nm_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    sts_d   = sts_q;
    addr_d  = addr_q;
    used_d  = used_q;
    fsum_d  = fsum_q;
    big_d   = big_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = cur_q;
    re      = 1'b0;
    raddr   = '0;
    case (state_q)
      S_INIT: begin
        we    = 1'b1;
        wdata = '{is_free: 1'b1, offset: '0,
                  size: SizeW'(HEAP_BYTES - HEADER_BYTES)};
      end
      S_IDLE: begin
        if (in_acc) begin
          func_d  = in_item_i.func;
          need_d  = ({1'b0, in_item_i.req_size} + NeedW'(3)) & ~NeedW'(3);
          faddr_d = in_item_i.free_addr;
          idx_d   = '0;
          addr_d  = '0;
          used_d  = '0;
          fsum_d  = '0;
          big_d   = '0;
          nm_d    = 1'b0;
          sts_d   = zero_req ? STS_NULL : STS_OK;
        end
      end
      S_FIND_RD: begin
        re    = 1'b1;
        raddr = IDX_W'(idx_q);
      end
      S_FIND_CHK: begin
        if (hit) begin
          cur_d = rdata;
          if (func_q == FUNC_ALLOC) begin
            split_d = can_split;
            addr_d  = paddr;
            k_d     = cnt_q;
          end else if (rdata.is_free) begin
            sts_d = STS_DBL;
          end
        end else begin
          prev_d = rdata;
          idx_d  = idx_q + CNT_W'(1);
          if (last_ent) sts_d = (func_q == FUNC_ALLOC) ? STS_OOM : STS_UNK;
        end
      end
      S_SHR_RD: begin
        re    = 1'b1;
        raddr = IDX_W'(k_q - CNT_W'(1));
      end
      S_SHR_WR: begin
        we    = 1'b1;
        waddr = IDX_W'(k_q);
        wdata = rdata;
        k_d   = k_q - CNT_W'(1);
      end
      S_SPLIT_WR: begin
        we    = 1'b1;
        waddr = IDX_W'(idx_q + CNT_W'(1));
        wdata = '{is_free: 1'b1,
                  offset:  cur_q.offset + HDR + SizeW'(need_q),
                  size:    cur_q.size - SizeW'(need_q) - HDR};
        cnt_d = cnt_q + CNT_W'(1);
      end
      S_ALC_WR: begin
        we    = 1'b1;
        waddr = IDX_W'(idx_q);
        wdata = '{is_free: 1'b0, offset: cur_q.offset,
                  size: split_q ? SizeW'(need_q) : cur_q.size};
      end
      S_NXT_RD: begin
        re    = 1'b1;
        raddr = IDX_W'(idx_q + CNT_W'(1));
      end
      S_NXT_CHK: begin
        nm_d = rdata.is_free;
        if (rdata.is_free) cur_d.size = cur_q.size + HDR + rdata.size;
      end
      S_MERGE: begin
        // Freed block (next merged if free) joins a free previous one, else stays.
        we = 1'b1;
        if (pm) begin
          waddr = IDX_W'(idx_q - CNT_W'(1));
          wdata = '{is_free: 1'b1, offset: prev_q.offset,
                    size: prev_q.size + HDR + cur_q.size};
        end else begin
          waddr = IDX_W'(idx_q);
          wdata = '{is_free: 1'b1, offset: cur_q.offset, size: cur_q.size};
        end
        k_d    = CNT_W'(dst);
        dist_d = mdist;
        if (!mrg_more) cnt_d = cnt_q - CNT_W'(mdist);
      end
      S_SHL_RD: begin
        re    = 1'b1;
        raddr = IDX_W'(EW'(k_q) + EW'(dist_q));
      end
      S_SHL_WR: begin
        we    = 1'b1;
        waddr = IDX_W'(k_q);
        wdata = rdata;
        k_d   = k_q + CNT_W'(1);
        if (!shl_more) cnt_d = cnt_q - CNT_W'(dist_q);
      end
      S_STAT_RD: begin
        re    = 1'b1;
        raddr = IDX_W'(k_q);
      end
      S_STAT_ACC: begin
        k_d = k_q + CNT_W'(1);
        if (rdata.is_free) begin
          fsum_d = fsum_q + rdata.size;
          if (rdata.size > big_q) big_d = rdata.size;
        end else begin
          used_d = used_q + rdata.size + HDR;
        end
      end
      default: ;
    endcase
    // statistics walk starts at entry 0
    if (state_d == S_STAT_RD && state_q != S_STAT_ACC) k_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= CNT_W'(1);
      base_q      <= 32'h0040_0000;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) base_q <= cfg_data_i;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_d_reg: begin end
    func_q  <= func_d;
    need_q  <= need_d;
    faddr_q <= faddr_d;
    idx_q   <= idx_d;
    k_q     <= k_d;
    dist_q  <= dist_d;
    split_q <= split_d;
    nm_q    <= nm_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    sts_q   <= sts_d;
    addr_q  <= addr_d;
    used_q  <= used_d;
    fsum_q  <= fsum_d;
    big_q   <= big_d;
    if (state_q == S_DONE && out_free) begin
      out_q <= '{status: sts_q, alloc_addr: addr_q, used_bytes: used_q,
                 free_bytes: fsum_q, largest_free: big_q,
                 block_count: CntOW'(cnt_q)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Block count stays within the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (EW'(cnt_q) <= EW'(MAX_BLOCKS)))
    else $error("block count out of range");

  // The RAM is never written and read at the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re && (waddr == raddr)))
    else $error("RAM read/write overlap");

  // A new result only comes out of the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result without finished item");

  // Count changes only while the table is being reshaped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_SPLIT_WR ||
      $past(state_q) == S_MERGE || $past(state_q) == S_SHL_WR))
    else $error("unexpected block count change");

endmodule

### hw/rtl/ffha_ram.sv
// Block table memory: one write port, one registered read port.
module ffha_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  ffha_pkg::ent_t             wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output ffha_pkg::ent_t             rdata_o
);
  import ffha_pkg::*;

  ent_t mem [DEPTH];
  ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/first_fit_heap_allocator_tb.sv
// Testbench for the first-fit heap allocator: directed and random alloc/free traffic.
module first_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int unsigned HeapBytes = 4194304;
  localparam int unsigned HdrBytes  = 16;
  localparam int unsigned SplitMin  = 8;
  localparam int unsigned TableMax  = 256;
  localparam int unsigned StallLimit = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [31:0] cfg_data;
  in_item_t in_item;
  out_item_t out_item;

  first_fit_heap_allocator uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Shadow of the block table.
  logic [31:0] base_addr;
  logic [31:0] blk_off [TableMax];
  logic [31:0] blk_len [TableMax];
  logic        blk_free[TableMax];
  int unsigned blk_cnt;

  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  logic [31:0] live_addrs[$];   // payload offsets from the base handed out, for free traffic
  int unsigned errors;
  int unsigned idle_pct;        // idling percentage for both sides
  int unsigned stall_cycles;
  bit stim_done;
  bit in_taken;                 // item on the input was accepted at the last rising edge

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] payload_of(input int unsigned idx);
    return base_addr + blk_off[idx] + HdrBytes;
  endfunction

  function automatic void drop_entry(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < blk_cnt; k++) begin
      blk_off[k] = blk_off[k+1]; blk_len[k] = blk_len[k+1]; blk_free[k] = blk_free[k+1];
    end
    blk_cnt--;
  endfunction

  // Apply one request to the shadow table and produce its result item.
  function automatic out_item_t heap_apply(input in_item_t req);
    out_item_t r;
    logic [31:0] need, used, freeb, big;
    int unsigned i;
    r = '0;
    if (req.func == FUNC_ALLOC) begin
      if (req.req_size == 0) r.status = STS_NULL;
      else begin
        need = (32'(req.req_size) + 3) & ~32'd3;
        for (i = 0; i < blk_cnt; i++) if (blk_free[i] && blk_len[i] >= need) break;
        if (i >= blk_cnt) r.status = STS_OOM;
        else begin
          if (blk_len[i] >= need + HdrBytes + SplitMin && blk_cnt < TableMax) begin
            for (int unsigned k = blk_cnt; k > i + 1; k--) begin
              blk_off[k] = blk_off[k-1]; blk_len[k] = blk_len[k-1];
              blk_free[k] = blk_free[k-1];
            end
            blk_off[i+1] = blk_off[i] + HdrBytes + need;
            blk_len[i+1] = blk_len[i] - need - HdrBytes;
            blk_free[i+1] = 1'b1;
            blk_len[i] = need;
            blk_cnt++;
          end
          blk_free[i] = 1'b0;
          r.status = STS_OK;
          r.alloc_addr = payload_of(i);
        end
      end
    end else begin
      if (req.free_addr == 0) r.status = STS_NULL;
      else begin
        for (i = 0; i < blk_cnt; i++) if (payload_of(i) == req.free_addr) break;
        if (i >= blk_cnt) r.status = STS_UNK;
        else if (blk_free[i]) r.status = STS_DBL;
        else begin
          r.status = STS_OK;
          blk_free[i] = 1'b1;
          if (i + 1 < blk_cnt && blk_free[i+1]) begin
            blk_len[i] += HdrBytes + blk_len[i+1];
            drop_entry(i + 1);
          end
          if (i > 0 && blk_free[i-1]) begin
            blk_len[i-1] += HdrBytes + blk_len[i];
            drop_entry(i);
          end
        end
      end
    end
    used = 0; freeb = 0; big = 0;
    for (int unsigned k = 0; k < blk_cnt; k++) begin
      if (blk_free[k]) begin
        freeb += blk_len[k];
        if (blk_len[k] > big) big = blk_len[k];
      end else used += blk_len[k] + HdrBytes;
    end
    r.used_bytes = used[22:0];
    r.free_bytes = freeb[22:0];
    r.largest_free = big[22:0];
    r.block_count = blk_cnt[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
  end

  // Driver: presents queued requests, dropping each one once it is accepted.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        void'(pending_reqs.pop_front());
      end
      if (!in_valid || in_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_reqs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Prediction happens at the accepting edge so the model order matches the block.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      out_item_t e;
      e = heap_apply(in_item);
      expected_results.push_back(e);
      if (e.status == STS_OK && in_item.func == FUNC_ALLOC)
        live_addrs.push_back(e.alloc_addr - base_addr);
    end
  end

  // Monitor: compares each result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item", 32'd0, 32'd0);
      end else begin
        out_item_t w;
        w = expected_results.pop_front();
        if (out_item.status != w.status) report_mismatch("status", 32'(out_item.status), 32'(w.status));
        if (out_item.alloc_addr != w.alloc_addr)
          report_mismatch("alloc_addr", out_item.alloc_addr, w.alloc_addr);
        if (out_item.used_bytes != w.used_bytes)
          report_mismatch("used_bytes", 32'(out_item.used_bytes), 32'(w.used_bytes));
        if (out_item.free_bytes != w.free_bytes)
          report_mismatch("free_bytes", 32'(out_item.free_bytes), 32'(w.free_bytes));
        if (out_item.largest_free != w.largest_free)
          report_mismatch("largest_free", 32'(out_item.largest_free), 32'(w.largest_free));
        if (out_item.block_count != w.block_count)
          report_mismatch("block_count", 32'(out_item.block_count), 32'(w.block_count));
      end
    end
  end

  // Watchdog: counts cycles with no accepted item on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic in_item_t mk_alloc(input logic [22:0] sz);
    in_item_t it;
    it = '0; it.func = FUNC_ALLOC; it.req_size = sz;
    return it;
  endfunction

  function automatic in_item_t mk_free(input logic [31:0] a);
    in_item_t it;
    it = '0; it.func = FUNC_FREE; it.free_addr = a;
    return it;
  endfunction

  // Random stream: mostly small allocations and frees of live addresses.
  task automatic queue_random(input int unsigned n);
    in_item_t it;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0: it = mk_alloc(23'($urandom));                    // huge, often OOM
        1: it = mk_free($urandom);                          // noise address
        2: it = '{func: FUNC_FREE, req_size: 23'($urandom), free_addr: '0};
        3, 4, 5, 6, 7, 8, 9, 10: it = mk_alloc(23'($urandom_range(1, 300)));
        11: it = mk_alloc(23'($urandom_range(1, 70000)));
        default: begin
          // free a handed-out block; stale entries exercise double free
          it = mk_free(base_addr + 32'(HdrBytes));
          it.req_size = 23'($urandom);
          it.free_addr = (live_addrs.size() > 0)
                       ? base_addr + live_addrs[$urandom_range(live_addrs.size() - 1)]
                       : $urandom;
          if ($urandom_range(15) == 0) it.free_addr += 4;  // inside a payload
        end
      endcase
      pending_reqs.push_back(it);
    end
  endtask

  task automatic drain_and_settle();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (6 * TableMax + 50) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    base_addr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_valid = 0; out_ready = 0; cfg_valid = 0; cfg_data = '0; in_item = '0;
    errors = 0; stall_cycles = 0; idle_pct = 27; stim_done = 0; in_taken = 0;
    base_addr = 32'h0040_0000;
    blk_off[0] = 0; blk_len[0] = HeapBytes - HdrBytes; blk_free[0] = 1'b1; blk_cnt = 1;
    rst_n = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: zero size, null free, rounding, OOM, double free, unknown address.
    pending_reqs.push_back(mk_alloc(23'd0));
    pending_reqs.push_back(mk_free(32'd0));
    pending_reqs.push_back(mk_alloc(23'd1));
    pending_reqs.push_back(mk_alloc(23'h7FFFFF));
    pending_reqs.push_back(mk_alloc(23'd4194288));
    pending_reqs.push_back(mk_free(32'h0040_0010));
    pending_reqs.push_back(mk_free(32'h0040_0010));
    pending_reqs.push_back(mk_free(32'hFFFF_FFFF));
    pending_reqs.push_back(mk_alloc(23'd4194280));          // leaves no room to split
    pending_reqs.push_back(mk_free(32'h0040_0010));
    pending_reqs.push_back(mk_alloc(23'd5));
    pending_reqs.push_back(mk_alloc(23'd8));
    pending_reqs.push_back(mk_alloc(23'd12));
    pending_reqs.push_back(mk_free(32'h0040_0028));         // middle block
    pending_reqs.push_back(mk_free(32'h0040_0014));         // inside a payload
    pending_reqs.push_back(mk_free(32'h0040_0010));         // merges with next
    pending_reqs.push_back(mk_free(32'h0040_0040));         // merges both sides
    drain_and_settle();

    // Fill the table to its limit so the whole-block path is hit.
    for (int k = 0; k < TableMax + 4; k++) pending_reqs.push_back(mk_alloc(23'd4));
    pending_reqs.push_back(mk_alloc(23'd4000000));
    drain_and_settle();
    // Release a run at the bottom and the whole last block.
    for (int k = 0; k < 64; k++)
      pending_reqs.push_back(mk_free(32'h0040_0010 + 32'(k) * 20));
    pending_reqs.push_back(mk_free(32'h0040_0010 + 32'(TableMax - 1) * 20));
    drain_and_settle();

    // Random phases over several bases, extremes included; one phase has no idling.
    write_base(32'hFFFF_FF00);
    queue_random(120);
    drain_and_settle();
    write_base(32'h0000_0000);
    idle_pct = 0;
    queue_random(80);
    drain_and_settle();
    idle_pct = 27;
    write_base($urandom);
    queue_random(80);
    drain_and_settle();
    write_base(32'hFFFF_FFFF);
    queue_random(70);
    drain_and_settle();
    write_base(32'h0040_0000);
    queue_random(60);
    drain_and_settle();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
